// ----- rtl/wsfd_pkg.sv -----
// Shared types, codes and helpers for the WebSocket frame deframer.
package wsfd_pkg;

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_KEY  = 3'd3,
        PH_DATA = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ACT_DELIVER = 2'd0,
        ACT_PONG    = 2'd1,
        ACT_CLOSE   = 2'd2,
        ACT_IGNORE  = 2'd3
    } action_t;

    localparam logic [3:0]  OP_TEXT   = 4'h1;
    localparam logic [3:0]  OP_BINARY = 4'h2;
    localparam logic [3:0]  OP_CLOSE  = 4'h8;
    localparam logic [3:0]  OP_PING   = 4'h9;

    localparam logic [6:0]  LEN_EXT16 = 7'd126;
    localparam logic [6:0]  LEN_EXT64 = 7'd127;

    localparam logic [3:0]  EXT16_BYTES = 4'd2;
    localparam logic [3:0]  EXT64_BYTES = 4'd8;
    localparam logic [3:0]  KEY_BYTES   = 4'd4;

    localparam logic [63:0] MAX_FRAME_RESET = 64'd16777216;

    function automatic action_t action_of(input logic [3:0] op);
        action_t a;
        case (op)
            OP_TEXT, OP_BINARY: a = ACT_DELIVER;
            OP_PING:            a = ACT_PONG;
            OP_CLOSE:           a = ACT_CLOSE;
            default:            a = ACT_IGNORE;
        endcase
        return a;
    endfunction

endpackage

// ----- rtl/websocket_frame_deframer_core.sv -----
// Top level of the WebSocket frame deframer: byte-stream header parse and payload unmask.
//
//  channel | handshake                | payload
//  --------+--------------------------+--------------------------------------------
//  in      | in_valid / in_stall      | in_byte
//  out     | out_valid / out_stall    | kind, data, frame_opcode, action, last
//  cfg     | cfg_valid / cfg_ready    | cfg_data (max_frame_bytes)
//
// One item per cycle sustained while out_stall does not hold the result register. An
// accepted byte lands in the input register, then the combinational parse logic
// updates the frame state and loads the result register, which drives the outputs.
// The parse stage advances whenever the result register is empty or being
// drained; out_stall therefore backs up to in_stall within the same cycle.
// Reset (rst_n low, asynchronous) returns to the first-header-byte phase,
// clears the halt flag and loads max_frame_bytes with 16 MiB.
module websocket_frame_deframer_core
    import wsfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input byte channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [7:0]  data,
    output logic [3:0]  frame_opcode,
    output logic [1:0]  action,
    output logic        last,
    // configuration channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cfg_data
);

    // input register
    logic        in_vld_reg;
    logic [7:0]  in_byte_reg;

    // frame state
    phase_t      phase_reg,  phase_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        mask_on_reg, mask_on_next;
    logic [63:0] remain_reg, remain_next;
    logic [3:0]  count_reg,  count_next;
    logic [31:0] key_reg,    key_next;
    logic [1:0]  kidx_reg,   kidx_next;
    logic        halted_reg, halted_next;

    logic [63:0] max_len_reg;

    // result register
    logic        out_vld_reg;
    logic [1:0]  kind_reg;
    logic [7:0]  data_reg;
    logic [3:0]  op_out_reg;
    logic [1:0]  act_out_reg;
    logic        last_reg;

    // parse stage outputs
    logic        res_vld;
    kind_t       res_kind;
    logic [7:0]  res_data;
    logic        res_last;

    logic        out_free;
    logic        advance;

    assign out_free  = !out_vld_reg || !out_stall;
    assign advance   = in_vld_reg && out_free;
    assign in_stall  = in_vld_reg && !out_free;
    assign cfg_ready = 1'b1;

    assign out_valid    = out_vld_reg;
    assign kind         = kind_reg;
    assign data         = data_reg;
    assign frame_opcode = op_out_reg;
    assign action       = act_out_reg;
    assign last         = last_reg;

    // parse one byte against the current frame state
    always_comb
    begin
        logic [63:0] len_w;
        logic [3:0]  cnt_w;
        logic        len_done;
        logic        hdr_done;
        logic [7:0]  kb;

        phase_next   = phase_reg;
        opcode_next  = opcode_reg;
        mask_on_next = mask_on_reg;
        remain_next  = remain_reg;
        count_next   = count_reg;
        key_next     = key_reg;
        kidx_next    = kidx_reg;
        halted_next  = halted_reg;
        res_vld      = 1'b0;
        res_kind     = KIND_BYTE;
        res_data     = 8'h00;
        res_last     = 1'b0;
        len_w        = remain_reg;
        cnt_w        = count_reg - 4'd1;
        len_done     = 1'b0;
        hdr_done     = 1'b0;
        kb           = 8'h00;

        case (kidx_reg)
            2'd0:    kb = key_reg[31:24];
            2'd1:    kb = key_reg[23:16];
            2'd2:    kb = key_reg[15:8];
            default: kb = key_reg[7:0];
        endcase

        if (!halted_reg)
        begin
            case (phase_reg)
                PH_HDR0:
                begin
                    opcode_next = in_byte_reg[3:0];
                    phase_next  = PH_HDR1;
                end
                PH_HDR1:
                begin
                    mask_on_next = in_byte_reg[7];
                    key_next     = '0;
                    if (in_byte_reg[6:0] == LEN_EXT16)
                    begin
                        remain_next = '0;
                        count_next  = EXT16_BYTES;
                        phase_next  = PH_EXT;
                    end
                    else if (in_byte_reg[6:0] == LEN_EXT64)
                    begin
                        remain_next = '0;
                        count_next  = EXT64_BYTES;
                        phase_next  = PH_EXT;
                    end
                    else
                    begin
                        len_w    = {57'd0, in_byte_reg[6:0]};
                        len_done = 1'b1;
                    end
                end
                PH_EXT:
                begin
                    // big-endian length, shifted in a byte at a time
                    len_w       = {remain_reg[55:0], in_byte_reg};
                    remain_next = len_w;
                    count_next  = cnt_w;
                    if (cnt_w == 4'd0)
                        len_done = 1'b1;
                end
                PH_KEY:
                begin
                    key_next   = {key_reg[23:0], in_byte_reg};
                    count_next = cnt_w;
                    if (cnt_w == 4'd0)
                        hdr_done = 1'b1;
                end
                PH_DATA:
                begin
                    kidx_next   = kidx_reg + 2'd1;
                    remain_next = remain_reg - 64'd1;
                    res_vld     = 1'b1;
                    res_kind    = KIND_BYTE;
                    res_data    = in_byte_reg ^ kb;
                    res_last    = (remain_reg == 64'd1);
                    if (res_last)
                    begin
                        if (opcode_reg == OP_CLOSE)
                            halted_next = 1'b1;
                        phase_next = PH_HDR0;
                    end
                end
                default:
                begin
                    phase_next = PH_HDR0;
                end
            endcase

            if (len_done)
            begin
                remain_next = len_w;
                if (len_w > max_len_reg)
                begin
                    res_vld     = 1'b1;
                    res_kind    = KIND_ERROR;
                    halted_next = 1'b1;
                    phase_next  = PH_HDR0;
                end
                else if (mask_on_next)
                begin
                    count_next = KEY_BYTES;
                    phase_next = PH_KEY;
                end
                else
                begin
                    hdr_done = 1'b1;
                end
            end

            // header (and key, if masked) complete: open the payload or end an empty frame
            if (hdr_done)
            begin
                kidx_next = 2'd0;
                if (len_w == 64'd0)
                begin
                    res_vld  = 1'b1;
                    res_kind = KIND_EMPTY;
                    res_last = 1'b1;
                    if (opcode_next == OP_CLOSE)
                        halted_next = 1'b1;
                    phase_next = PH_HDR0;
                end
                else
                begin
                    phase_next = PH_DATA;
                end
            end
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (!in_stall)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_byte_reg <= in_byte;
    end

    // frame state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HDR0;
            opcode_reg  <= 4'd0;
            mask_on_reg <= 1'b0;
            remain_reg  <= 64'd0;
            count_reg   <= 4'd0;
            key_reg     <= 32'd0;
            kidx_reg    <= 2'd0;
            halted_reg  <= 1'b0;
            max_len_reg <= MAX_FRAME_RESET;
        end
        else
        begin
            if (advance)
            begin
                phase_reg   <= phase_next;
                opcode_reg  <= opcode_next;
                mask_on_reg <= mask_on_next;
                remain_reg  <= remain_next;
                count_reg   <= count_next;
                key_reg     <= key_next;
                kidx_reg    <= kidx_next;
                halted_reg  <= halted_next;
            end
            if (cfg_valid && cfg_ready)
                max_len_reg <= cfg_data;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (out_free)
            out_vld_reg <= advance && res_vld;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_vld)
        begin
            kind_reg    <= res_kind;
            data_reg    <= res_data;
            op_out_reg  <= opcode_next;
            act_out_reg <= action_of(opcode_next);
            last_reg    <= res_last;
        end
    end

endmodule
